/* hw/rtl/ffra_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ffra_pkg;

    // request transaction fields
    typedef struct packed {
        logic [1:0]  func;
        logic [14:0] region_offset;
        logic [14:0] region_size;
        logic [14:0] target_size;
    } t_req;

    // result transaction fields
    typedef struct packed {
        logic [14:0] result_offset;
        logic        ok;
        logic [2:0]  status;
    } t_rsp;

    // one free table entry
    typedef struct packed {
        logic [14:0] offset;
        logic [14:0] size;
    } t_entry;

    // request codes
    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_REALLOC = 2'd1;
    localparam logic [1:0] FUNC_CHECK   = 2'd2;

    // status codes
    localparam logic [2:0] STAT_OK           = 3'd0;
    localparam logic [2:0] STAT_NO_FIT       = 3'd1;
    localparam logic [2:0] STAT_OUT_OF_ARENA = 3'd2;
    localparam logic [2:0] STAT_RESERVED     = 3'd3;
    localparam logic [2:0] STAT_TABLE_FULL   = 3'd4;

    // sequencer states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RANGE,
        S_SCAN,
        S_HIT,
        S_MOVE,
        S_APPEND,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* hw/rtl/ffra_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffra_table #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [AW-1:0]         i_waddr,
    input  ffra_pkg::t_entry     i_wdata,
    input  wire [AW-1:0]         i_raddr,
    output ffra_pkg::t_entry     o_rdata
);
    import ffra_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    // single write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* hw/rtl/ffra_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ffra_ctrl #(
    parameter int ARENA_BYTES    = 16384,
    parameter int FREE_ENTRIES   = 128,
    parameter int RESERVED_BYTES = 2048,
    parameter int IW             = 7
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    output logic                 o_busy,
    input  ffra_pkg::t_req       i_req,
    output logic                 o_valid,
    output ffra_pkg::t_rsp       o_rsp,
    output logic                 o_tbl_we,
    output logic [IW-1:0]        o_tbl_waddr,
    output ffra_pkg::t_entry     o_tbl_wdata,
    output logic [IW-1:0]        o_tbl_raddr,
    input  ffra_pkg::t_entry     i_tbl_rdata
);
    import ffra_pkg::*;

    localparam int          CW      = $clog2(FREE_ENTRIES + 1);
    localparam logic [15:0] ARENA16 = 16'(ARENA_BYTES);
    localparam logic [15:0] RES16   = 16'(RESERVED_BYTES);
    localparam logic [14:0] INIT_OFF  = 15'(RESERVED_BYTES);
    localparam logic [14:0] INIT_SIZE = 15'(ARENA_BYTES - RESERVED_BYTES);
    localparam logic [CW-1:0] FULL_CNT = CW'(FREE_ENTRIES);

    t_state        r_state, n_state;
    t_req          r_req, n_req;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [IW-1:0] r_cidx, n_cidx;
    logic          r_pend, n_pend;
    logic [IW-1:0] r_hidx, n_hidx;
    logic [14:0]   r_hoff, n_hoff;
    logic [14:0]   r_hsize, n_hsize;
    logic [14:0]   r_res_off, n_res_off;
    logic          r_ok, n_ok;
    logic [2:0]    r_status, n_status;

    logic [14:0]   need;
    logic [15:0]   off16;
    logic [15:0]   size16;
    logic [2:0]    range_stat;
    logic          fits;
    logic          exact;
    logic [CW-1:0] last;

    // size that the scan looks for
    assign need = (r_req.func == FUNC_REALLOC) ? r_req.target_size : r_req.region_size;

    // range check of the existing region
    assign off16  = {1'b0, r_req.region_offset};
    assign size16 = {1'b0, r_req.region_size};
    always_comb begin
        if ((off16 > ARENA16) || (size16 > (ARENA16 - off16))) begin
            range_stat = STAT_OUT_OF_ARENA;
        end else if (off16 < RES16) begin
            range_stat = STAT_RESERVED;
        end else begin
            range_stat = STAT_OK;
        end
    end

    // shared compare unit for the first-fit scan
    assign fits  = r_pend && (i_tbl_rdata.size >= need);
    assign exact = (r_hsize == need);
    assign last  = r_count - 1'b1;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= CW'(1);
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_cidx    <= n_cidx;
        r_hidx    <= n_hidx;
        r_hoff    <= n_hoff;
        r_hsize   <= n_hsize;
        r_res_off <= n_res_off;
        r_ok      <= n_ok;
        r_status  <= n_status;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_count     = r_count;
        n_idx       = r_idx;
        n_cidx      = r_cidx;
        n_pend      = r_pend;
        n_hidx      = r_hidx;
        n_hoff      = r_hoff;
        n_hsize     = r_hsize;
        n_res_off   = r_res_off;
        n_ok        = r_ok;
        n_status    = r_status;
        o_tbl_we    = 1'b0;
        o_tbl_waddr = r_hidx;
        o_tbl_wdata = i_tbl_rdata;
        o_tbl_raddr = r_idx[IW-1:0];

        case (r_state)
            // seed the single free region after reset
            S_INIT: begin
                o_tbl_we    = 1'b1;
                o_tbl_waddr = '0;
                o_tbl_wdata = '{offset: INIT_OFF, size: INIT_SIZE};
                n_count     = CW'(1);
                n_state     = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_state = S_RANGE;
                end
            end
            // decode the request
            S_RANGE: begin
                n_idx     = '0;
                n_pend    = 1'b0;
                n_ok      = 1'b0;
                n_res_off = '0;
                n_status  = STAT_NO_FIT;
                case (r_req.func)
                    FUNC_ALLOC: begin
                        n_state = S_SCAN;
                    end
                    FUNC_REALLOC: begin
                        if (range_stat != STAT_OK) begin
                            n_status = range_stat;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    FUNC_CHECK: begin
                        n_status = range_stat;
                        if (range_stat == STAT_OK) begin
                            n_res_off = r_req.region_offset;
                            n_ok      = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            // one table read issued and one entry compared per cycle
            S_SCAN: begin
                if (fits) begin
                    n_hidx  = r_cidx;
                    n_hoff  = i_tbl_rdata.offset;
                    n_hsize = i_tbl_rdata.size;
                    n_pend  = 1'b0;
                    n_state = S_HIT;
                end else if (r_idx < r_count) begin
                    n_cidx = r_idx[IW-1:0];
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend   = 1'b0;
                    n_status = STAT_NO_FIT;
                    n_state  = S_DONE;
                end
            end
            // take the region: split in place or fetch the last entry; a reallocate split on a full table is refused
            S_HIT: begin
                if ((r_req.func == FUNC_REALLOC) && !exact && (r_count >= FULL_CNT)) begin
                    n_status = STAT_TABLE_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_res_off = r_hoff;
                    n_ok      = 1'b1;
                    n_status  = STAT_OK;
                    if (exact) begin
                        o_tbl_raddr = last[IW-1:0];
                        n_state     = S_MOVE;
                    end else begin
                        o_tbl_we    = 1'b1;
                        o_tbl_waddr = r_hidx;
                        o_tbl_wdata = '{offset: r_hoff + need, size: r_hsize - need};
                        n_state     = (r_req.func == FUNC_REALLOC) ? S_APPEND : S_DONE;
                    end
                end
            end
            // last entry moves into the freed slot
            S_MOVE: begin
                o_tbl_we    = 1'b1;
                o_tbl_waddr = r_hidx;
                o_tbl_wdata = i_tbl_rdata;
                n_count     = last;
                n_state     = (r_req.func == FUNC_REALLOC) ? S_APPEND : S_DONE;
            end
            // release the old region at the table end
            S_APPEND: begin
                o_tbl_we    = 1'b1;
                o_tbl_waddr = r_count[IW-1:0];
                o_tbl_wdata = '{offset: r_req.region_offset, size: r_req.region_size};
                n_count     = r_count + 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result transaction
    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_rsp   = '{result_offset: r_res_off, ok: r_ok, status: r_status};

endmodule

`default_nettype wire

/* hw/rtl/first_fit_region_allocator_top.sv */
// sequence: check and range-rejected requests pass from S_RANGE straight to S_DONE;
//   allocate and reallocate go through the first-fit scan in S_SCAN, which
//   reads one table entry per cycle through the single read port of the free table
// throughput: one transaction at a time, busy stays high through the result strobe cycle
// reset: synchronous active low; after reset the S_INIT state seeds the free table, busy high
// the result strobe o_valid lasts one cycle and the receiver cannot stall it
`timescale 1ns / 1ps
`default_nettype none

module first_fit_region_allocator_top #(
    parameter int ARENA_BYTES    = 16384,
    parameter int FREE_ENTRIES   = 128,
    parameter int RESERVED_BYTES = 2048
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                start,
    output logic               busy,
    input  ffra_pkg::t_req     i_req,
    output logic               o_valid,
    output ffra_pkg::t_rsp     o_rsp
);
    import ffra_pkg::*;

    localparam int IW = $clog2(FREE_ENTRIES);

    logic          tbl_we;
    logic [IW-1:0] tbl_waddr;
    t_entry        tbl_wdata;
    logic [IW-1:0] tbl_raddr;
    t_entry        tbl_rdata;

    // sequencer with range check and scan compare
    ffra_ctrl #(
        .ARENA_BYTES    (ARENA_BYTES),
        .FREE_ENTRIES   (FREE_ENTRIES),
        .RESERVED_BYTES (RESERVED_BYTES),
        .IW             (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp),
        .o_tbl_we    (tbl_we),
        .o_tbl_waddr (tbl_waddr),
        .o_tbl_wdata (tbl_wdata),
        .o_tbl_raddr (tbl_raddr),
        .i_tbl_rdata (tbl_rdata)
    );

    // free region table
    ffra_table #(
        .DEPTH (FREE_ENTRIES),
        .AW    (IW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

endmodule

`default_nettype wire

/* tb/ffra_checker.sv */
`timescale 1ns / 1ps

module ffra_checker #(
    parameter int ARENA_BYTES    = 16384,
    parameter int FREE_ENTRIES   = 128,
    parameter int RESERVED_BYTES = 2048
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire                              i_busy,
    input  ffra_pkg::t_req                   i_req,
    input  wire                              i_valid,
    input  ffra_pkg::t_rsp                   i_rsp,
    output int                               o_errors,
    output int                               o_owed,
    output int                               o_free_count,
    output logic [FREE_ENTRIES-1:0][14:0]    o_free_sizes
);

    import ffra_pkg::*;

    // shadow copy of the free table
    logic [FREE_ENTRIES-1:0][14:0] free_off;
    logic [FREE_ENTRIES-1:0][14:0] free_sz;
    int free_cnt = 1;

    // results still owed by the block, oldest first
    t_rsp owed_rsp[$];
    t_rsp want;
    int   errors = 0;
    int   owed = 0;

    assign o_errors     = errors;
    assign o_owed       = owed;
    assign o_free_count = free_cnt;
    assign o_free_sizes = free_sz;

    // out of arena wins over the reserved area
    function automatic logic [2:0] span_status(logic [14:0] off, logic [14:0] sz);
        int o;
        int s;
        o = int'(off);
        s = int'(sz);
        if (o > ARENA_BYTES || s > ARENA_BYTES - o) return STAT_OUT_OF_ARENA;
        if (o < RESERVED_BYTES) return STAT_RESERVED;
        return STAT_OK;
    endfunction

    // first entry large enough, or -1
    function automatic int find_hole(logic [14:0] sz);
        for (int i = 0; i < free_cnt; i++) begin
            if (free_sz[i] >= sz) return i;
        end
        return -1;
    endfunction

    // exact fit pulls the last entry into the slot, otherwise split from the front
    function automatic logic [14:0] carve(int idx, logic [14:0] sz);
        logic [14:0] off;
        off = free_off[idx];
        if (free_sz[idx] == sz) begin
            free_off[idx] = free_off[free_cnt-1];
            free_sz[idx]  = free_sz[free_cnt-1];
            free_cnt--;
        end else begin
            free_sz[idx]  = free_sz[idx] - sz;
            free_off[idx] = free_off[idx] + sz;
        end
        return off;
    endfunction

    // expected result of one request, updating the shadow table
    function automatic t_rsp serve_request(t_req r);
        t_rsp rsp;
        int   idx;
        rsp.result_offset = '0;
        rsp.ok            = 1'b0;
        rsp.status        = STAT_NO_FIT;
        case (r.func)
            FUNC_ALLOC: begin
                idx = find_hole(r.region_size);
                if (idx >= 0) begin
                    rsp.result_offset = carve(idx, r.region_size);
                    rsp.ok            = 1'b1;
                    rsp.status        = STAT_OK;
                end
            end
            FUNC_REALLOC: begin
                rsp.status = span_status(r.region_offset, r.region_size);
                if (rsp.status == STAT_OK) begin
                    idx = find_hole(r.target_size);
                    if (idx < 0) begin
                        rsp.status = STAT_NO_FIT;
                    end else if (free_sz[idx] != r.target_size &&
                                 free_cnt >= FREE_ENTRIES) begin
                        rsp.status = STAT_TABLE_FULL;
                    end else begin
                        rsp.result_offset  = carve(idx, r.target_size);
                        free_off[free_cnt] = r.region_offset;
                        free_sz[free_cnt]  = r.region_size;
                        free_cnt++;
                        rsp.ok = 1'b1;
                    end
                end
            end
            FUNC_CHECK: begin
                rsp.status = span_status(r.region_offset, r.region_size);
                if (rsp.status == STAT_OK) begin
                    rsp.result_offset = r.region_offset;
                    rsp.ok            = 1'b1;
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic compare_field(string name, logic [14:0] exp_val, logic [14:0] act_val);
        if (act_val !== exp_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
        end
    endtask

    // results first, then the request transaction of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            free_cnt    = 1;
            free_off[0] = 15'(RESERVED_BYTES);
            free_sz[0]  = 15'(ARENA_BYTES - RESERVED_BYTES);
            owed_rsp.delete();
        end else begin
            if (i_valid) begin
                if (owed_rsp.size() == 0) begin
                    errors++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got offset %0d ok %0d status %0d"},
                             $time, i_rsp.result_offset, i_rsp.ok, i_rsp.status);
                end else begin
                    want = owed_rsp.pop_front();
                    compare_field("result_offset", want.result_offset, i_rsp.result_offset);
                    compare_field("ok", 15'(want.ok), 15'(i_rsp.ok));
                    compare_field("status", 15'(want.status), 15'(i_rsp.status));
                end
            end
            if (i_start && !i_busy) begin
                owed_rsp.push_back(serve_request(i_req));
            end
        end
        owed = owed_rsp.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    import ffra_pkg::*;

    localparam int ARENA_BYTES    = 16384;
    localparam int FREE_ENTRIES   = 128;
    localparam int RESERVED_BYTES = 2048;
    localparam int RANDOM_ITEMS   = 700;
    localparam int STALL_LIMIT    = 4000;
    localparam int DRAIN_CYCLES   = FREE_ENTRIES + 16;

    // the block answers this request code with a no-fit result
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    int errors;
    int owed;
    int free_count;
    logic [FREE_ENTRIES-1:0][14:0] free_sizes;

    int idle_cycles = 0;
    int gap_mode    = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    first_fit_region_allocator_top #(
        .ARENA_BYTES    (ARENA_BYTES),
        .FREE_ENTRIES   (FREE_ENTRIES),
        .RESERVED_BYTES (RESERVED_BYTES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    ffra_checker #(
        .ARENA_BYTES    (ARENA_BYTES),
        .FREE_ENTRIES   (FREE_ENTRIES),
        .RESERVED_BYTES (RESERVED_BYTES)
    ) chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_valid      (o_valid),
        .i_rsp        (o_rsp),
        .o_errors     (errors),
        .o_owed       (owed),
        .o_free_count (free_count),
        .o_free_sizes (free_sizes)
    );

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // unused fields carry random bits
    function automatic t_req make_req(logic [1:0] func, int off, int rsz, int nsz);
        t_req r;
        r               = t_req'($bits(t_req)'({$urandom, $urandom}));
        r.func          = func;
        r.region_offset = 15'(off);
        r.region_size   = 15'(rsz);
        r.target_size   = 15'(nsz);
        return r;
    endfunction

    // mostly legal regions, with reserved, overrun and edge cases mixed in
    function automatic void random_region(output logic [14:0] off, output logic [14:0] sz);
        int o;
        case ($urandom_range(0, 9))
            0: begin
                off = 15'($urandom_range(0, RESERVED_BYTES - 1));
                sz  = 15'($urandom_range(0, 512));
            end
            1: begin
                off = 15'($urandom);
                sz  = 15'($urandom);
            end
            2: begin
                o   = $urandom_range(RESERVED_BYTES, ARENA_BYTES);
                off = 15'(o);
                sz  = 15'(ARENA_BYTES - o + 1);
            end
            3: begin
                o   = $urandom_range(RESERVED_BYTES, ARENA_BYTES);
                off = 15'(o);
                sz  = 15'(ARENA_BYTES - o);
            end
            default: begin
                o   = $urandom_range(RESERVED_BYTES, ARENA_BYTES - 1);
                off = 15'(o);
                sz  = 15'($urandom_range(0, (ARENA_BYTES - o < 512) ? ARENA_BYTES - o : 512));
            end
        endcase
    endfunction

    // aim at an existing entry size for exact fits, else small, wide, huge or zero
    function automatic logic [14:0] pick_size(bit aim);
        int pick;
        pick = aim ? 0 : $urandom_range(0, 9);
        if (free_count == 0 && pick <= 3) pick = 4;
        case (pick)
            0, 1, 2, 3: return free_sizes[$urandom_range(0, free_count - 1)];
            4, 5, 6:    return 15'($urandom_range(0, 255));
            7:          return 15'($urandom_range(0, ARENA_BYTES));
            8:          return 15'($urandom);
            default:    return '0;
        endcase
    endfunction

    // gap before the request, then hold it until the block takes it
    task automatic issue(t_req r);
        int gap;
        gap = (gap_mode == 0) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    initial begin
        t_req        r;
        logic [14:0] off;
        logic [14:0] sz;
        int          served;
        int          issued;
        int          roll;
        int          p_alloc;
        int          p_realloc;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: range check edges and the unused request code
        gap_mode = $urandom_range(0, 1);
        issue(make_req(FUNC_CHECK, RESERVED_BYTES, 0, $urandom));
        issue(make_req(FUNC_CHECK, 0, 0, $urandom));
        issue(make_req(FUNC_CHECK, ARENA_BYTES, 0, $urandom));
        issue(make_req(FUNC_CHECK, ARENA_BYTES + 1, 0, $urandom));
        issue(make_req(FUNC_CHECK, 32767, 32767, $urandom));
        issue(make_req(FUNC_CHECK, RESERVED_BYTES - 1, 100, $urandom));
        issue(make_req(FUNC_CHECK, 4000, ARENA_BYTES - 4000 + 1, $urandom));
        issue(make_req(FUNC_CHECK, 4000, ARENA_BYTES - 4000, $urandom));
        issue(make_req(FUNC_UNUSED, 32767, 32767, 32767));

        // directed: zero-size split, no fit, front split
        issue(make_req(FUNC_ALLOC, $urandom, 0, $urandom));
        issue(make_req(FUNC_ALLOC, $urandom, 32767, $urandom));
        issue(make_req(FUNC_ALLOC, $urandom, 100, $urandom));

        // directed: reallocate paths and a zero-size entry reaching slot 0
        issue(make_req(FUNC_REALLOC, RESERVED_BYTES, 100, 50));
        issue(make_req(FUNC_REALLOC, 1000, 10, 10));
        issue(make_req(FUNC_REALLOC, 20000, 5, 5));
        issue(make_req(FUNC_REALLOC, 2148, 0, 32767));
        issue(make_req(FUNC_REALLOC, 5000, 0, 0));
        issue(make_req(FUNC_ALLOC, $urandom, ARENA_BYTES - RESERVED_BYTES - 150, $urandom));
        issue(make_req(FUNC_ALLOC, $urandom, 0, $urandom));
        issue(make_req(FUNC_REALLOC, ARENA_BYTES, 0, 0));
        issue(make_req(FUNC_REALLOC, RESERVED_BYTES, ARENA_BYTES - RESERVED_BYTES, 100));
        issue(make_req(FUNC_CHECK, ARENA_BYTES, 1, $urandom));

        // random: keep the table from emptying, push it to full and back
        served = 0;
        issued = 0;
        while (served < RANDOM_ITEMS) begin
            if (issued % 32 == 0) gap_mode = $urandom_range(0, 2);
            issued++;
            if (free_count < 4) begin
                p_alloc   = 5;
                p_realloc = 85;
            end else if (free_count >= FREE_ENTRIES) begin
                p_alloc   = 50;
                p_realloc = 80;
            end else begin
                p_alloc   = 35;
                p_realloc = 75;
            end
            roll = $urandom_range(0, 99);
            r    = make_req(FUNC_UNUSED, $urandom, $urandom, $urandom);
            if (roll < p_alloc) begin
                r.func        = FUNC_ALLOC;
                r.region_size = pick_size(free_count >= FREE_ENTRIES);
            end else if (roll < p_realloc) begin
                random_region(off, sz);
                r.func          = FUNC_REALLOC;
                r.region_offset = off;
                r.region_size   = sz;
                r.target_size   = pick_size(1'b0);
            end else if (roll < 95) begin
                random_region(off, sz);
                r.func          = FUNC_CHECK;
                r.region_offset = off;
                r.region_size   = sz;
            end
            issue(r);
            if (r.func != FUNC_UNUSED) served++;
        end
        start = 1'b0;

        // drain outstanding results, then allow for a stray one
        while (owed != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* first_fit_region_allocator_top.f */
hw/rtl/ffra_pkg.sv
hw/rtl/ffra_table.sv
hw/rtl/ffra_ctrl.sv
hw/rtl/first_fit_region_allocator_top.sv
tb/ffra_checker.sv
tb/tb.sv
